// ----- rtl/xeu_pkg.sv -----
// xeu_pkg: shared types, codes and helpers of the x86 16-bit execute unit
// no dependencies; used by xeu_front, xeu_back and the top level
`default_nettype none

package xeu_pkg;

	// default size of the data memory in bytes (power of two)
	localparam int MEM_BYTES_DEF = 65536;

	// command codes of the input item
	localparam logic [2:0] CMD_MOV = 3'd0;
	localparam logic [2:0] CMD_ADD = 3'd1;
	localparam logic [2:0] CMD_SUB = 3'd2;
	localparam logic [2:0] CMD_CMP = 3'd3;
	localparam logic [2:0] CMD_JMP = 3'd4;

	// source kinds
	localparam logic [1:0] SRC_REG = 2'd0;
	localparam logic [1:0] SRC_MEM = 2'd1;

	// jump conditions
	localparam logic [4:0] COND_ALWAYS = 5'd0;
	localparam logic [4:0] COND_Z      = 5'd1;
	localparam logic [4:0] COND_NZ     = 5'd2;
	localparam logic [4:0] COND_C      = 5'd3;
	localparam logic [4:0] COND_NC     = 5'd4;
	localparam logic [4:0] COND_L      = 5'd5;
	localparam logic [4:0] COND_GE     = 5'd6;
	localparam logic [4:0] COND_LE     = 5'd7;
	localparam logic [4:0] COND_G      = 5'd8;
	localparam logic [4:0] COND_BE     = 5'd9;
	localparam logic [4:0] COND_A      = 5'd10;
	localparam logic [4:0] COND_S      = 5'd11;
	localparam logic [4:0] COND_NS     = 5'd12;
	localparam logic [4:0] COND_P      = 5'd13;
	localparam logic [4:0] COND_NP     = 5'd14;
	localparam logic [4:0] COND_O      = 5'd15;
	localparam logic [4:0] COND_NO     = 5'd16;

	// status codes
	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_END   = 2'd1;
	localparam logic [1:0] STATUS_RANGE = 2'd2;

	// flag bit positions
	localparam int FL_C = 0;
	localparam int FL_P = 1;
	localparam int FL_A = 2;
	localparam int FL_Z = 3;
	localparam int FL_S = 4;
	localparam int FL_O = 5;

	typedef enum logic [2:0] {
		OP_MOV,
		OP_ADD,
		OP_SUB,
		OP_CMP,
		OP_JMP,
		OP_NOP
	} op_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_ADDR,
		ST_EXEC
	} state_t;

	// classified item as it sits in the queue
	typedef struct packed {
		op_t         op;
		logic [4:0]  cond;
		logic        dest_mem;
		logic [3:0]  dest_reg;
		logic        src_is_reg;
		logic        src_is_mem;
		logic [3:0]  src_reg;
		logic [15:0] imm;
		logic        a1_en;
		logic [2:0]  a1;
		logic        a2_en;
		logic [2:0]  a2;
		logic [15:0] disp;
		logic        neg;
		logic [2:0]  len;
	} item_t;

	// queue head towards the back end
	typedef struct packed {
		logic  valid;
		item_t item;
	} head_t;

	// condition test against the current flags
	function automatic logic cond_met(input logic [4:0] c, input logic [5:0] f);
		logic z, cy, s, o, p;
		logic r;
		z  = f[FL_Z];
		cy = f[FL_C];
		s  = f[FL_S];
		o  = f[FL_O];
		p  = f[FL_P];
		case (c)
			COND_Z:  r = z;
			COND_NZ: r = !z;
			COND_C:  r = cy;
			COND_NC: r = !cy;
			COND_L:  r = s != o;
			COND_GE: r = s == o;
			COND_LE: r = z || (s != o);
			COND_G:  r = !z && (s == o);
			COND_BE: r = cy || z;
			COND_A:  r = !cy && !z;
			COND_S:  r = s;
			COND_NS: r = !s;
			COND_P:  r = p;
			COND_NP: r = !p;
			COND_O:  r = o;
			COND_NO: r = !o;
			default: r = 1'b1;
		endcase
		return r;
	endfunction

	// register read with byte halves, zero-extended
	function automatic logic [15:0] reg_read(input logic [7:0][15:0] rf, input logic [3:0] i);
		logic [15:0] v;
		if (!i[3]) begin
			v = rf[i[2:0]];
		end else if (!i[2]) begin
			v = {8'h00, rf[{1'b0, i[1:0]}][15:8]};
		end else begin
			v = {8'h00, rf[{1'b0, i[1:0]}][7:0]};
		end
		return v;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/xeu_ifs.sv -----
// xeu_ifs: handshake channels of the execute unit (instruction, result, config)
// no dependencies
`default_nettype none

interface xeu_instr_if;
	logic        valid;
	logic        ready;
	logic [2:0]  command;
	logic [4:0]  jump_condition;
	logic        dest_is_memory;
	logic [3:0]  dest_reg;
	logic [1:0]  src_kind;
	logic [3:0]  src_reg;
	logic [15:0] immediate;
	logic [3:0]  addr_reg;
	logic [3:0]  addr_second_reg;
	logic [15:0] addr_disp;
	logic        addr_disp_negate;
	logic [2:0]  instr_length;

	modport source (
		output valid, command, jump_condition, dest_is_memory, dest_reg, src_kind,
		       src_reg, immediate, addr_reg, addr_second_reg, addr_disp,
		       addr_disp_negate, instr_length,
		input  ready
	);
	modport sink (
		input  valid, command, jump_condition, dest_is_memory, dest_reg, src_kind,
		       src_reg, immediate, addr_reg, addr_second_reg, addr_disp,
		       addr_disp_negate, instr_length,
		output ready
	);
endinterface

interface xeu_result_if;
	logic        valid;
	logic        ready;
	logic [15:0] new_ip;
	logic [15:0] dest_old_value;
	logic [15:0] dest_new_value;
	logic [5:0]  flag_bits;
	logic        jump_taken;
	logic [1:0]  status;

	modport source (
		output valid, new_ip, dest_old_value, dest_new_value, flag_bits, jump_taken, status,
		input  ready
	);
	modport sink (
		input  valid, new_ip, dest_old_value, dest_new_value, flag_bits, jump_taken, status,
		output ready
	);
endinterface

interface xeu_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/xeu_ram.sv -----
// xeu_ram: generic single-write, single-read RAM with registered read data
// no dependencies
`default_nettype none

module xeu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/xeu_front.sv -----
// xeu_front: accepts instruction items, classifies them, holds them in a two-entry queue
// depends on xeu_pkg and xeu_ifs
`default_nettype none

module xeu_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	xeu_instr_if.sink           instr,
	input  wire logic           clearing,
	input  wire logic           pop,
	output xeu_pkg::head_t      head
);

	xeu_pkg::item_t cls;
	xeu_pkg::item_t entry_q [2];
	logic           wp_q;
	logic           rp_q;
	logic [1:0]     cnt_q;
	logic           push;
	logic           do_pop;

	// classification of the incoming item
	always_comb begin
		case (instr.command)
			xeu_pkg::CMD_MOV: cls.op = xeu_pkg::OP_MOV;
			xeu_pkg::CMD_ADD: cls.op = xeu_pkg::OP_ADD;
			xeu_pkg::CMD_SUB: cls.op = xeu_pkg::OP_SUB;
			xeu_pkg::CMD_CMP: cls.op = xeu_pkg::OP_CMP;
			xeu_pkg::CMD_JMP: cls.op = xeu_pkg::OP_JMP;
			default:          cls.op = xeu_pkg::OP_NOP;
		endcase
		cls.cond       = (instr.jump_condition > xeu_pkg::COND_NO) ?
		                 xeu_pkg::COND_ALWAYS : instr.jump_condition;
		cls.dest_mem   = instr.dest_is_memory;
		cls.dest_reg   = instr.dest_reg;
		cls.src_is_reg = instr.src_kind == xeu_pkg::SRC_REG;
		cls.src_is_mem = instr.src_kind == xeu_pkg::SRC_MEM;
		cls.src_reg    = instr.src_reg;
		cls.imm        = instr.immediate;
		cls.a1_en      = !instr.addr_reg[3];
		cls.a1         = instr.addr_reg[2:0];
		cls.a2_en      = !instr.addr_second_reg[3];
		cls.a2         = instr.addr_second_reg[2:0];
		cls.disp       = instr.addr_disp;
		cls.neg        = instr.addr_disp_negate;
		cls.len        = instr.instr_length;
	end

	// queue handshake
	assign instr.ready = (cnt_q != 2'd2) && !clearing;
	assign push        = instr.valid && instr.ready;
	assign do_pop      = pop && (cnt_q != 2'd0);
	assign head.valid  = cnt_q != 2'd0;
	assign head.item   = entry_q[rp_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wp_q] <= cls;
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= !wp_q;
			end
			if (do_pop) begin
				rp_q <= !rp_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, do_pop};
		end
	end

endmodule

`default_nettype wire

// ----- rtl/xeu_back.sv -----
// xeu_back: executes queued items against registers, IP, flags and the banked data memory
// depends on xeu_pkg, xeu_ifs and xeu_ram
`default_nettype none

module xeu_back #(
	parameter int MEM_BYTES = xeu_pkg::MEM_BYTES_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  xeu_pkg::head_t      head,
	output logic                pop,
	output logic                clearing,
	xeu_cfg_if.sink             cfg,
	xeu_result_if.source        result
);

	localparam int AW   = $clog2(MEM_BYTES);
	localparam int RW   = AW - 1;
	localparam int ROWS = MEM_BYTES / 2;

	xeu_pkg::state_t  state_q, state_d;
	logic [7:0][15:0] regs_q;
	logic [15:0]      ip_q;
	logic [5:0]       flags_q;
	logic [15:0]      plen_q;
	logic [RW-1:0]    clr_q;
	xeu_pkg::item_t   cur_q;
	logic             odd_q;
	logic [RW-1:0]    row_q;

	logic             rvalid_q;
	logic [15:0]      rip_q, rold_q, rnew_q;
	logic [5:0]       rflags_q;
	logic             rtaken_q;
	logic [1:0]       rstatus_q;

	xeu_pkg::item_t   h;
	logic [15:0]      ea;
	logic [RW-1:0]    rd_row0, rd_row1;
	logic             rd_en;
	logic [7:0]       d0, d1;
	logic [15:0]      mem_word;
	logic             fire;

	logic [15:0]      src, old_v, res, fall;
	logic [16:0]      sum17, dif17;
	logic [4:0]       nib_sub;
	logic             cy, ov, aux;
	logic [17:0]      tgt;
	logic             at_end, alu_op, store;
	logic [15:0]      o_ip;
	logic [5:0]       o_flags;
	logic             o_taken;
	logic [1:0]       o_status;
	logic [15:0]      o_old, o_new;

	logic             b0_we, b1_we;
	logic [RW-1:0]    b0_wa, b1_wa;
	logic [7:0]       b0_wd, b1_wd;

	// address stage: effective address from the queue head
	assign h = head.item;
	always_comb begin
		ea = (h.a1_en ? regs_q[h.a1] : 16'h0000) + (h.a2_en ? regs_q[h.a2] : 16'h0000);
		ea = h.neg ? ea - h.disp : ea + h.disp;
		rd_row1 = ea[AW-1:1];
		rd_row0 = ea[0] ? rd_row1 + RW'(1) : rd_row1;
	end

	assign rd_en    = (state_q == xeu_pkg::ST_ADDR) && head.valid;
	assign pop      = rd_en;
	assign clearing = state_q == xeu_pkg::ST_CLEAR;

	// memory word from the two byte banks
	assign mem_word = odd_q ? {d0, d1} : {d1, d0};

	// execute stage
	always_comb begin
		src   = cur_q.src_is_reg ? xeu_pkg::reg_read(regs_q, cur_q.src_reg) :
		        cur_q.src_is_mem ? mem_word : cur_q.imm;
		old_v = cur_q.dest_mem ? mem_word : xeu_pkg::reg_read(regs_q, cur_q.dest_reg);
		sum17   = {1'b0, old_v} + {1'b0, src};
		dif17   = {1'b0, old_v} - {1'b0, src};
		nib_sub = {1'b0, old_v[3:0]} - {1'b0, src[3:0]};
		fall    = ip_q + {13'b0, cur_q.len};
		tgt     = {2'b00, ip_q} + 18'd2 + {{10{cur_q.imm[7]}}, cur_q.imm[7:0]};
		at_end  = ip_q >= plen_q;
		alu_op  = (cur_q.op == xeu_pkg::OP_ADD) || (cur_q.op == xeu_pkg::OP_SUB) ||
		          (cur_q.op == xeu_pkg::OP_CMP);

		res = src;
		cy  = 1'b0;
		ov  = 1'b0;
		aux = 1'b0;
		if (cur_q.op == xeu_pkg::OP_ADD) begin
			res = sum17[15:0];
			cy  = sum17[16];
			ov  = (old_v[15] == src[15]) && (old_v[15] != res[15]);
			aux = sum17[4] ^ old_v[4] ^ src[4];
		end else if (alu_op) begin
			res = dif17[15:0];
			cy  = dif17[16];
			ov  = (old_v[15] != src[15]) && (old_v[15] != res[15]);
			aux = nib_sub[4];
		end

		o_ip     = fall;
		o_old    = 16'h0000;
		o_new    = 16'h0000;
		o_flags  = flags_q;
		o_taken  = 1'b0;
		o_status = xeu_pkg::STATUS_OK;
		store    = 1'b0;
		if (at_end) begin
			o_ip     = ip_q;
			o_status = xeu_pkg::STATUS_END;
		end else begin
			case (cur_q.op)
				xeu_pkg::OP_JMP: begin
					if (xeu_pkg::cond_met(cur_q.cond, flags_q)) begin
						if (tgt[17] || (tgt[16:0] > {1'b0, plen_q})) begin
							o_ip     = ip_q;
							o_status = xeu_pkg::STATUS_RANGE;
						end else begin
							o_ip    = tgt[15:0];
							o_taken = 1'b1;
						end
					end
				end
				xeu_pkg::OP_MOV, xeu_pkg::OP_ADD, xeu_pkg::OP_SUB, xeu_pkg::OP_CMP: begin
					o_old = old_v;
					if (cur_q.op == xeu_pkg::OP_CMP) begin
						o_new = old_v;
					end else begin
						store = 1'b1;
						o_new = (!cur_q.dest_mem && cur_q.dest_reg[3]) ? {8'h00, res[7:0]} : res;
					end
					if (alu_op) begin
						o_flags = {ov, res[15], res == 16'h0000, aux, ~^res[7:0], cy};
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign fire = (state_q == xeu_pkg::ST_EXEC) && (!rvalid_q || result.ready);

	// bank write ports: clearing pass or store of a memory word
	always_comb begin
		if (state_q == xeu_pkg::ST_CLEAR) begin
			b0_we = 1'b1;
			b1_we = 1'b1;
			b0_wa = clr_q;
			b1_wa = clr_q;
			b0_wd = 8'h00;
			b1_wd = 8'h00;
		end else begin
			b0_we = fire && store && cur_q.dest_mem;
			b1_we = b0_we;
			b0_wa = odd_q ? row_q + RW'(1) : row_q;
			b1_wa = row_q;
			b0_wd = odd_q ? res[15:8] : res[7:0];
			b1_wd = odd_q ? res[7:0] : res[15:8];
		end
	end

	// even-address byte bank
	xeu_ram #(.WIDTH(8), .DEPTH(ROWS)) u_bank0 (
		.clk   (clk),
		.we    (b0_we),
		.waddr (b0_wa),
		.wdata (b0_wd),
		.re    (rd_en),
		.raddr (rd_row0),
		.rdata (d0)
	);

	// odd-address byte bank
	xeu_ram #(.WIDTH(8), .DEPTH(ROWS)) u_bank1 (
		.clk   (clk),
		.we    (b1_we),
		.waddr (b1_wa),
		.wdata (b1_wd),
		.re    (rd_en),
		.raddr (rd_row1),
		.rdata (d1)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			xeu_pkg::ST_CLEAR: begin
				if (clr_q == RW'(ROWS - 1)) begin
					state_d = xeu_pkg::ST_ADDR;
				end
			end
			xeu_pkg::ST_ADDR: begin
				if (head.valid) begin
					state_d = xeu_pkg::ST_EXEC;
				end
			end
			xeu_pkg::ST_EXEC: begin
				if (fire) begin
					state_d = xeu_pkg::ST_ADDR;
				end
			end
			default: state_d = xeu_pkg::ST_CLEAR;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= xeu_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// architectural state, config and clear counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q  <= '0;
			ip_q    <= 16'h0000;
			flags_q <= 6'h00;
			plen_q  <= 16'h0000;
			clr_q   <= '0;
		end else begin
			if (cfg.valid) begin
				plen_q <= cfg.data;
			end
			if (state_q == xeu_pkg::ST_CLEAR) begin
				clr_q <= clr_q + RW'(1);
			end
			if (fire) begin
				ip_q    <= o_ip;
				flags_q <= o_flags;
				if (store && !cur_q.dest_mem) begin
					if (!cur_q.dest_reg[3]) begin
						regs_q[cur_q.dest_reg[2:0]] <= res;
					end else if (!cur_q.dest_reg[2]) begin
						regs_q[{1'b0, cur_q.dest_reg[1:0]}][15:8] <= res[7:0];
					end else begin
						regs_q[{1'b0, cur_q.dest_reg[1:0]}][7:0] <= res[7:0];
					end
				end
			end
		end
	end

	// item in execution and its address split
	always_ff @(posedge clk) begin
		if (rd_en) begin
			cur_q <= h;
			odd_q <= ea[0];
			row_q <= rd_row1;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rvalid_q <= 1'b0;
		end else if (fire) begin
			rvalid_q <= 1'b1;
		end else if (result.ready) begin
			rvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rip_q     <= o_ip;
			rold_q    <= o_old;
			rnew_q    <= o_new;
			rflags_q  <= o_flags;
			rtaken_q  <= o_taken;
			rstatus_q <= o_status;
		end
	end

	assign cfg.ready             = 1'b1;
	assign result.valid          = rvalid_q;
	assign result.new_ip         = rip_q;
	assign result.dest_old_value = rold_q;
	assign result.dest_new_value = rnew_q;
	assign result.flag_bits      = rflags_q;
	assign result.jump_taken     = rtaken_q;
	assign result.status         = rstatus_q;

endmodule

`default_nettype wire

// ----- rtl/x86_16bit_execute_unit_core.sv -----
// x86_16bit_execute_unit_core: top level of the 16-bit x86 execute unit
// depends on xeu_pkg, xeu_ifs, xeu_front, xeu_back (and xeu_ram below it)
//
// Usage:
//   instr  - decoded instruction items in (valid/ready), one result item each
//   result - result items out (valid/ready): new IP, old/new destination,
//            flags, jump taken and status
//   cfg    - write channel for program_length, always ready; write it only
//            while the block is idle
// Timing: an accepted item waits in the queue; at the head it is popped
//   in the address state (effective address and memory read), then
//   executes and writes back in the execute state once the result register
//   is free. The back end works on one item at a time, as the synchronous
//   read of the byte-banked data memory must come ahead of the execute step.
// Reset: registers, IP, flags and program_length clear at once; the data
//   memory is then zeroed by a sweep over its MEM_BYTES/2 rows, during which
//   instr.ready is low (cfg writes are still taken).
// Stall: a result waits in the output register; the front queue keeps
//   taking up to two items meanwhile, then drops instr.ready.
// MEM_BYTES must be a power of two.
`default_nettype none

module x86_16bit_execute_unit_core #(
	parameter int MEM_BYTES = xeu_pkg::MEM_BYTES_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	xeu_instr_if.sink     instr,
	xeu_result_if.source  result,
	xeu_cfg_if.sink       cfg
);

	xeu_pkg::head_t head;
	logic           pop;
	logic           clearing;

	// front end: accept, classify, queue
	xeu_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.instr    (instr),
		.clearing (clearing),
		.pop      (pop),
		.head     (head)
	);

	// back end: execute
	xeu_back #(.MEM_BYTES(MEM_BYTES)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.pop      (pop),
		.clearing (clearing),
		.cfg      (cfg),
		.result   (result)
	);

`ifndef SYNTHESIS
	// no item taken during the memory clearing sweep
	a_no_accept_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !instr.ready)
		else $error("item accepted during memory clear");

	// a taken jump always reports ok status
	a_taken_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.jump_taken) |-> (result.status == xeu_pkg::STATUS_OK))
		else $error("taken jump with error status");

	// non-ok status leaves destinations zero
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && (result.status != xeu_pkg::STATUS_OK)) |->
		((result.dest_old_value == 16'h0000) && (result.dest_new_value == 16'h0000)))
		else $error("error result with destination data");

	// pop only when the queue holds an item
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head.valid)
		else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire
